// ----- hdl/oxpc_pkg.sv -----
// Shared definitions for the XOR-shift OAEP padding codec.
// Field widths, default mask sizes, request codes and the control/status bundles
// between the sequencer and the serial mask engine. No dependencies.
`timescale 1ns / 1ps

package oxpc_pkg;

  localparam int MASK_WIDTH_DEF = 32;
  localparam int PAD_WIDTH_DEF  = 16;

  localparam int CW_W     = 48;
  localparam int MSG_W    = 32;
  localparam int PAD_IN_W = 16;

  localparam logic REQ_ENCODE = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  typedef struct packed {
    logic grow_start;
    logic fold_start;
  } oxpc_cmd_t;

  typedef struct packed {
    logic grow_busy;
    logic fold_busy;
  } oxpc_sts_t;

endpackage

// ----- hdl/oxpc_mask_engine.sv -----
// Serial mask engine: the grow mask G and the fold mask H, one shift-XOR step
// per clock each. Depends on oxpc_pkg for the command and status bundles.
`timescale 1ns / 1ps

module oxpc_mask_engine import oxpc_pkg::*; #(
  parameter int MASK_WIDTH = MASK_WIDTH_DEF,
  parameter int PAD_WIDTH  = PAD_WIDTH_DEF,
  parameter int GROW_W     = (MASK_WIDTH > PAD_WIDTH) ? MASK_WIDTH : PAD_WIDTH,
  parameter int FOLD_W     = (GROW_W > CW_W - PAD_WIDTH) ? GROW_W : CW_W - PAD_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  oxpc_cmd_t            cmd,
  input  logic [PAD_WIDTH-1:0] grow_seed,
  input  logic [FOLD_W-1:0]    fold_seed,
  output oxpc_sts_t            sts,
  output logic [GROW_W-1:0]    grow_mask,
  output logic [PAD_WIDTH-1:0] fold_mask
);

  logic [GROW_W-1:0]    t_r, t_nxt;
  logic [GROW_W-1:0]    gacc_r, gacc_nxt;
  logic                 gbusy_r, gbusy_nxt;
  logic [FOLD_W-1:0]    p_r, p_nxt;
  logic [PAD_WIDTH-1:0] facc_r, facc_nxt;
  logic                 fbusy_r, fbusy_nxt;

  // Growing goes on while the accumulator is non-zero and still shorter than
  // the mask width. A zero pad never grows, so it stops at once with G = 0.
  function automatic logic grow_more(input logic [GROW_W-1:0] acc);
    grow_more = (acc != '0) && (acc[GROW_W-1:MASK_WIDTH-1] == '0);
  endfunction

  // Folding goes on while the value is at least PAD_WIDTH bits long.
  function automatic logic fold_more(input logic [FOLD_W-1:0] p);
    fold_more = |p[FOLD_W-1:PAD_WIDTH-1];
  endfunction

  always_comb begin
    t_nxt     = t_r;
    gacc_nxt  = gacc_r;
    gbusy_nxt = gbusy_r;
    if (cmd.grow_start) begin
      t_nxt     = GROW_W'(grow_seed);
      gacc_nxt  = t_nxt;
      gbusy_nxt = grow_more(gacc_nxt);
    end else if (gbusy_r) begin
      t_nxt     = t_r << 1;
      gacc_nxt  = gacc_r ^ t_nxt;
      gbusy_nxt = grow_more(gacc_nxt);
    end
  end

  always_comb begin
    p_nxt     = p_r;
    facc_nxt  = facc_r;
    fbusy_nxt = fbusy_r;
    if (cmd.fold_start) begin
      p_nxt     = fold_seed;
      facc_nxt  = '1;
      fbusy_nxt = fold_more(p_nxt);
    end else if (fbusy_r) begin
      facc_nxt  = facc_r ^ {1'b0, p_r[PAD_WIDTH-2:0]};
      p_nxt     = p_r >> 1;
      fbusy_nxt = fold_more(p_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbusy_r <= 1'b0;
      fbusy_r <= 1'b0;
    end else begin
      gbusy_r <= gbusy_nxt;
      fbusy_r <= fbusy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    gacc_r <= gacc_nxt;
    p_r    <= p_nxt;
    facc_r <= facc_nxt;
  end

  assign sts.grow_busy = gbusy_r;
  assign sts.fold_busy = fbusy_r;
  assign grow_mask     = gacc_r;
  assign fold_mask     = facc_r;

endmodule

// ----- hdl/oaep_xorshift_pad_codec.sv -----
// OAEP-style padding codec with XOR-shift masks, top level and sequencer.
// Depends on oxpc_pkg and oxpc_mask_engine.
//
// Usage: the in_ channel carries one request per item: in_req_type selects
// encode (message and pad into a codeword) or decode (codeword back into the
// message). The out_ channel returns exactly one item per request; the field
// that the request does not produce is zero. Both channels use valid/stall,
// an item moving on an edge where valid is high and stall is low.
// One item is handled at a time. The grow mask does one shift-XOR step per
// clock, MASK_WIDTH minus the bit length of the pad steps in all (none for a
// zero pad); the fold mask takes one step for each bit position of P1 from
// PAD_WIDTH-1 up to its highest set bit.
// The finished result sits in an output register, so a stalled receiver holds
// only that item; the codec takes the next request meanwhile and waits with
// its result until the output register is free.
// Reset empties the output register and returns the sequencer to idle.
`timescale 1ns / 1ps

module oaep_xorshift_pad_codec import oxpc_pkg::*; #(
  parameter int MASK_WIDTH = MASK_WIDTH_DEF,
  parameter int PAD_WIDTH  = PAD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [MSG_W-1:0]    in_message_in,
  input  logic [PAD_IN_W-1:0] in_random_pad,
  input  logic [CW_W-1:0]     in_codeword_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CW_W-1:0]     out_codeword_out,
  output logic [MSG_W-1:0]    out_message_out
);

  localparam int GW = (MASK_WIDTH > PAD_WIDTH) ? MASK_WIDTH : PAD_WIDTH;
  localparam int PW = (GW > CW_W - PAD_WIDTH) ? GW : CW_W - PAD_WIDTH;
  localparam logic [PW-1:0] M_ONES = {PW{1'b1}} >> (PW - MASK_WIDTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GROW = 2'd1;
  localparam logic [1:0] ST_FOLD = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic                 req_r, req_nxt;
  logic [PAD_WIDTH-1:0] pad_r, pad_nxt;
  logic [PW-1:0]        p1_r, p1_nxt;
  logic [PAD_WIDTH-1:0] p2_r, p2_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CW_W-1:0]      out_cw_r, out_cw_nxt;
  logic [MSG_W-1:0]     out_msg_r, out_msg_nxt;

  oxpc_cmd_t            cmd;
  oxpc_sts_t            sts;
  logic [PAD_WIDTH-1:0] grow_seed;
  logic [PW-1:0]        fold_seed;
  logic [GW-1:0]        grow_mask;
  logic [PAD_WIDTH-1:0] fold_mask;

  oxpc_mask_engine #(
    .MASK_WIDTH (MASK_WIDTH),
    .PAD_WIDTH  (PAD_WIDTH),
    .GROW_W     (GW),
    .FOLD_W     (PW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .grow_seed (grow_seed),
    .fold_seed (fold_seed),
    .sts       (sts),
    .grow_mask (grow_mask),
    .fold_mask (fold_mask)
  );

  assign in_stall = (state_r != ST_IDLE);

  // Encode runs grow then fold; decode runs fold then grow. p1_r holds P1 (in
  // an encode, from its grow on) and, after a decode's grow, the message.
  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    pad_nxt       = pad_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    out_valid_nxt = out_valid_r;
    out_cw_nxt    = out_cw_r;
    out_msg_nxt   = out_msg_r;
    cmd           = '0;
    grow_seed     = pad_r;
    fold_seed     = p1_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt = in_req_type;
          if (in_req_type == REQ_ENCODE) begin
            pad_nxt        = PAD_WIDTH'(in_random_pad);
            p1_nxt         = PW'(in_message_in) & M_ONES;
            grow_seed      = pad_nxt;
            cmd.grow_start = 1'b1;
            state_nxt      = ST_GROW;
          end else begin
            p1_nxt         = PW'(in_codeword_in >> PAD_WIDTH);
            p2_nxt         = in_codeword_in[PAD_WIDTH-1:0];
            fold_seed      = p1_nxt;
            cmd.fold_start = 1'b1;
            state_nxt      = ST_FOLD;
          end
        end
      end
      ST_GROW: begin
        if (!sts.grow_busy) begin
          p1_nxt = p1_r ^ PW'(grow_mask);
          if (req_r == REQ_ENCODE) begin
            fold_seed      = p1_nxt;
            cmd.fold_start = 1'b1;
            state_nxt      = ST_FOLD;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_FOLD: begin
        if (!sts.fold_busy) begin
          if (req_r == REQ_ENCODE) begin
            p2_nxt    = fold_mask ^ pad_r;
            state_nxt = ST_DONE;
          end else begin
            pad_nxt        = fold_mask ^ p2_r;
            grow_seed      = pad_nxt;
            cmd.grow_start = 1'b1;
            state_nxt      = ST_GROW;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          if (req_r == REQ_DECODE) begin
            out_cw_nxt  = '0;
            out_msg_nxt = MSG_W'(p1_r);
          end else begin
            out_cw_nxt  = CW_W'({p1_r, p2_r});
            out_msg_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r     <= req_nxt;
    pad_r     <= pad_nxt;
    p1_r      <= p1_nxt;
    p2_r      <= p2_nxt;
    out_cw_r  <= out_cw_nxt;
    out_msg_r <= out_msg_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_codeword_out = out_cw_r;
  assign out_message_out  = out_msg_r;

`ifndef SYNTHESIS
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("codec accepted a request but did not start working on it");

  a_one_mask: assert property (@(posedge clk) disable iff (!rst_n)
    !(sts.grow_busy && sts.fold_busy))
    else $error("grow and fold masks running at the same time");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!sts.grow_busy && !sts.fold_busy))
    else $error("mask engine still busy while the sequencer is idle");
`endif

endmodule
